// ----- rtl/sam_pkg.sv -----
// Shared types, opcodes and helper functions for the stack accumulator core.
`timescale 1ns / 1ps
package sam_pkg;

  localparam int PTR_W = 17;
  localparam int WORD_W = 64;

  localparam logic [PTR_W-1:0] STACK_TOP_RESET = 17'h10000;

  localparam logic [7:0] CFG_DATA_BASE = 8'd0;
  localparam logic [7:0] CFG_STACK_TOP = 8'd1;

  localparam logic [5:0] OP_EXIT    = 6'd0;
  localparam logic [5:0] OP_PRINT   = 6'd1;
  localparam logic [5:0] OP_IMM8    = 6'd2;
  localparam logic [5:0] OP_IMM64   = 6'd5;
  localparam logic [5:0] OP_LOAD8   = 6'd6;
  localparam logic [5:0] OP_LOAD64  = 6'd9;
  localparam logic [5:0] OP_STORE8  = 6'd10;
  localparam logic [5:0] OP_STORE64 = 6'd13;
  localparam logic [5:0] OP_PUSH8   = 6'd14;
  localparam logic [5:0] OP_PUSH64  = 6'd17;
  localparam logic [5:0] OP_POP8    = 6'd18;
  localparam logic [5:0] OP_POP64   = 6'd21;
  localparam logic [5:0] OP_JUMP    = 6'd22;
  localparam logic [5:0] OP_BNZ     = 6'd23;
  localparam logic [5:0] OP_BZ      = 6'd24;
  localparam logic [5:0] OP_CALL    = 6'd25;
  localparam logic [5:0] OP_RET     = 6'd26;
  localparam logic [5:0] OP_ADJUST  = 6'd27;
  localparam logic [5:0] OP_FRAME   = 6'd28;
  localparam logic [5:0] OP_GLOBAL  = 6'd29;
  localparam logic [5:0] OP_ADD     = 6'd30;
  localparam logic [5:0] OP_SUB     = 6'd31;
  localparam logic [5:0] OP_MUL     = 6'd32;
  localparam logic [5:0] OP_DIV     = 6'd33;
  localparam logic [5:0] OP_MOD     = 6'd34;
  localparam logic [5:0] OP_AND     = 6'd35;
  localparam logic [5:0] OP_OR      = 6'd36;
  localparam logic [5:0] OP_XOR     = 6'd37;
  localparam logic [5:0] OP_INC     = 6'd38;
  localparam logic [5:0] OP_DEC     = 6'd39;
  localparam logic [5:0] OP_NEG     = 6'd40;
  localparam logic [5:0] OP_NOT     = 6'd41;
  localparam logic [5:0] OP_LAND    = 6'd42;
  localparam logic [5:0] OP_LOR     = 6'd43;
  localparam logic [5:0] OP_LNOT    = 6'd44;
  localparam logic [5:0] OP_SHL     = 6'd45;
  localparam logic [5:0] OP_SHR     = 6'd46;
  localparam logic [5:0] OP_EQ      = 6'd47;
  localparam logic [5:0] OP_NE      = 6'd48;
  localparam logic [5:0] OP_GT      = 6'd49;
  localparam logic [5:0] OP_LT      = 6'd50;
  localparam logic [5:0] OP_GE      = 6'd51;
  localparam logic [5:0] OP_LE      = 6'd52;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_WRITE,
    ST_ARITH,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t kind;
  } md_req_t;

  function automatic logic [WORD_W-1:0] sext_size(input logic [WORD_W-1:0] v,
                                                  input logic [1:0] sz);
    case (sz)
      2'd0: return {{56{v[7]}}, v[7:0]};
      2'd1: return {{48{v[15]}}, v[15:0]};
      2'd2: return {{32{v[31]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic is_binary(input logic [5:0] op);
    return (op inside {[OP_ADD:OP_XOR], OP_LAND, OP_LOR, [OP_SHL:OP_LE]});
  endfunction

endpackage

// ----- rtl/sam_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/sam_muldiv.sv -----
// Iterative 64-bit multiplier and signed divider shared by the arithmetic opcodes.
`timescale 1ns / 1ps
module sam_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  sam_pkg::md_req_t              req,
  input  logic [sam_pkg::WORD_W-1:0]    a,
  input  logic [sam_pkg::WORD_W-1:0]    b,
  output logic                          done,
  output logic [sam_pkg::WORD_W-1:0]    result
);
  import sam_pkg::*;

  logic         busy;
  md_op_t       kind;
  logic [6:0]   cyc;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  prod;
  logic [63:0]  sum;
  logic [31:0]  mop_a;
  logic [31:0]  mop_b;
  logic         neg_a;
  logic         neg_b;
  logic [63:0]  quo;
  logic [63:0]  rem;
  logic [63:0]  dvs;
  logic [64:0]  rem_sh;
  logic [64:0]  diff;

  assign mop_a = (cyc == 7'd2) ? ma[63:32] : ma[31:0];
  assign mop_b = (cyc == 7'd1) ? mb[63:32] : mb[31:0];
  assign rem_sh = {rem, quo[63]};
  assign diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start &&
              ((kind == MD_MUL) ? (cyc == 7'd3) : (cyc == 7'd64));
      if (req.start) begin
        busy <= 1'b1;
        kind <= req.kind;
        cyc <= 7'd0;
        ma <= a;
        mb <= b;
        sum <= '0;
        neg_a <= a[63];
        neg_b <= b[63];
        quo <= a[63] ? (64'd0 - a) : a;
        dvs <= b[63] ? (64'd0 - b) : b;
        rem <= '0;
      end else if (busy) begin
        cyc <= cyc + 7'd1;
        if (kind == MD_MUL) begin
          prod <= mop_a * mop_b;
          case (cyc)
            7'd0: ;
            7'd1: sum <= prod;
            7'd2: sum <= sum + {prod[31:0], 32'd0};
            default: begin
              result <= sum + {prod[31:0], 32'd0};
              busy <= 1'b0;
            end
          endcase
        end else if (cyc < 7'd64) begin
          if (!diff[64]) begin
            rem <= diff[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
        end else begin
          if (kind == MD_DIV) begin
            result <= (neg_a ^ neg_b) ? (64'd0 - quo) : quo;
          end else begin
            result <= neg_a ? (64'd0 - rem) : rem;
          end
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/stack_accumulator_vm_core_top.sv -----
// Top level of the stack accumulator core: sequencer, byte memory and registers.
`timescale 1ns / 1ps
// Executes one decoded instruction per item on a 64-bit accumulator with a
// downward stack held in a byte-wide single-port memory. Memory is accessed
// one byte per cycle: binary operations read 8 bytes, stores read 8 and
// write up to 8, call writes 8 and return reads 8. Multiply, divide and
// modulo run in the shared iterative unit.
// The memory is not cleared at reset; reading bytes never written is undefined.
module stack_accumulator_vm_core_top #(
  parameter int MEM_BYTES = 65536,
  parameter int OPCODE_BYTES = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         operation,
  input  logic signed [63:0] immediate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        next_pc,
  output logic               printed,
  output logic signed [31:0] print_value,
  output logic               halted,
  output logic               fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import sam_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_LIMIT = 64'(MEM_BYTES);
  localparam logic [31:0] OP_STEP = 32'(OPCODE_BYTES);

  state_t state;
  state_t state_next;

  logic [5:0]       op_q;
  logic [63:0]      imm_q;
  logic [63:0]      acc;
  logic [PTR_W-1:0] sp;
  logic [PTR_W-1:0] fp;
  logic [31:0]      pc;
  logic             stopped;
  logic [15:0]      data_base;
  logic             fault_q;
  logic [63:0]      rdbuf;
  logic [63:0]      wdata;
  logic [AW-1:0]    xfer_base;
  logic [3:0]       xfer_len;
  logic [3:0]       cnt;

  logic [1:0]   sz;
  logic [3:0]   nbytes;
  logic [63:0]  n64;
  logic [63:0]  sp64;
  logic [63:0]  fp64;
  logic         start_fault;
  logic         needs_read;
  logic         needs_write;
  logic         needs_md;
  logic [63:0]  start_base;
  logic [3:0]   start_len;
  logic [63:0]  start_wdata;
  logic         read_done;
  logic [2:0]   rd_idx;
  logic [63:0]  rd_merged;
  logic         out_free;

  logic         mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]   mem_wdata;
  logic [7:0]   mem_rdata;

  md_req_t      md_req;
  logic         md_done;
  logic [63:0]  md_result;

  logic [63:0]      fin_acc;
  logic [PTR_W-1:0] fin_sp;
  logic [PTR_W-1:0] fin_fp;
  logic [31:0]      fin_pc;
  logic             fin_stop;
  logic             fin_print;
  logic             fin_halt;
  logic             fin_fault;

  function automatic logic span_ok(input logic [63:0] addr, input logic [63:0] len);
    return addr <= MEM_LIMIT - len;
  endfunction

  sam_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  sam_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .req   (md_req),
    .a     (rd_merged),
    .b     (acc),
    .done  (md_done),
    .result(md_result)
  );

  assign sz = op_q[1:0] - 2'd2;
  assign nbytes = 4'd1 << sz;
  assign n64 = 64'(nbytes);
  assign sp64 = 64'(sp);
  assign fp64 = 64'(fp);
  assign read_done = (cnt == xfer_len);
  assign rd_idx = 3'(cnt - 4'd1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    rd_merged = rdbuf;
    if (cnt != 4'd0) begin
      rd_merged[{rd_idx, 3'b000} +: 8] = mem_rdata;
    end
  end

  always_comb begin
    needs_read = 1'b0;
    needs_write = 1'b0;
    needs_md = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_MOD);
    start_fault = 1'b0;
    start_base = sp64;
    start_len = 4'd8;
    start_wdata = acc;
    if (is_binary(op_q)) begin
      needs_read = 1'b1;
      start_fault = !span_ok(sp64, 64'd8) ||
                    (((op_q == OP_DIV) || (op_q == OP_MOD)) && (acc == 64'd0));
    end else if (op_q inside {[OP_LOAD8:OP_LOAD64]}) begin
      needs_read = 1'b1;
      start_fault = !span_ok(acc, n64);
      start_base = acc;
      start_len = nbytes;
    end else if (op_q inside {[OP_STORE8:OP_STORE64]}) begin
      needs_read = 1'b1;
      needs_write = 1'b1;
      start_fault = !span_ok(sp64, 64'd8) || !span_ok(acc, n64);
    end else if (op_q inside {[OP_PUSH8:OP_PUSH64]}) begin
      needs_write = 1'b1;
      start_fault = (sp64 < n64) || (sp64 > MEM_LIMIT);
      start_base = sp64 - n64;
      start_len = nbytes;
    end else if (op_q inside {[OP_POP8:OP_POP64]}) begin
      needs_read = 1'b1;
      start_fault = !span_ok(sp64, n64);
      start_len = nbytes;
    end else if (op_q == OP_CALL) begin
      needs_write = 1'b1;
      start_fault = (sp64 < 64'd8) || (sp64 > MEM_LIMIT);
      start_base = sp64 - 64'd8;
      start_wdata = {pc + OP_STEP + 32'd4, 15'd0, fp};
    end else if (op_q == OP_RET) begin
      needs_read = 1'b1;
      start_fault = !span_ok(fp64, 64'd8);
      start_base = fp64;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stopped || start_fault) begin
          state_next = ST_FINISH;
        end else if (needs_read) begin
          state_next = ST_READ;
        end else if (needs_write) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        if (read_done) begin
          if (needs_write) begin
            state_next = ST_WRITE;
          end else if (needs_md) begin
            state_next = ST_ARITH;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        if (cnt == xfer_len - 4'd1) begin
          state_next = ST_FINISH;
        end
      end
      ST_ARITH: begin
        if (md_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    cfg_ready = (state == ST_IDLE);
    mem_we = (state == ST_WRITE);
    mem_addr = xfer_base + AW'(cnt);
    mem_wdata = wdata[{cnt[2:0], 3'b000} +: 8];
    md_req.start = (state == ST_READ) && read_done && needs_md;
    case (op_q)
      OP_DIV: md_req.kind = MD_DIV;
      OP_MOD: md_req.kind = MD_MOD;
      default: md_req.kind = MD_MUL;
    endcase
  end

  always_comb begin
    fin_acc = acc;
    fin_sp = sp;
    fin_fp = fp;
    fin_pc = pc + OP_STEP;
    fin_stop = stopped;
    fin_print = 1'b0;
    fin_halt = 1'b0;
    fin_fault = 1'b0;
    if (stopped) begin
      fin_pc = pc;
      fin_halt = 1'b1;
    end else if (fault_q) begin
      fin_pc = pc;
      fin_halt = 1'b1;
      fin_fault = 1'b1;
      fin_stop = 1'b1;
    end else begin
      if (is_binary(op_q)) begin
        fin_sp = sp + 17'd8;
      end
      case (op_q)
        OP_EXIT: begin
          fin_halt = 1'b1;
          fin_stop = 1'b1;
        end
        OP_PRINT: fin_print = 1'b1;
        OP_JUMP: fin_pc = imm_q[31:0];
        OP_BNZ: fin_pc = (acc != 64'd0) ? imm_q[31:0] : pc + OP_STEP + 32'd4;
        OP_BZ: fin_pc = (acc == 64'd0) ? imm_q[31:0] : pc + OP_STEP + 32'd4;
        OP_CALL: begin
          fin_sp = sp - 17'd8;
          fin_fp = sp - 17'd8;
          fin_pc = imm_q[31:0];
        end
        OP_RET: begin
          fin_fp = rdbuf[PTR_W-1:0];
          fin_pc = rdbuf[63:32];
          fin_sp = fp + 17'd8;
        end
        OP_ADJUST: begin
          fin_sp = sp + {imm_q[15], imm_q[15:0]};
          fin_pc = pc + OP_STEP + 32'd2;
        end
        OP_FRAME: begin
          fin_acc = fp64 + sext_size(imm_q, 2'd1);
          fin_pc = pc + OP_STEP + 32'd2;
        end
        OP_GLOBAL: begin
          fin_acc = 64'(data_base) + {32'd0, imm_q[31:0]};
          fin_pc = pc + OP_STEP + 32'd4;
        end
        OP_ADD: fin_acc = rdbuf + acc;
        OP_SUB: fin_acc = rdbuf - acc;
        OP_MUL, OP_DIV, OP_MOD: fin_acc = md_result;
        OP_AND: fin_acc = rdbuf & acc;
        OP_OR: fin_acc = rdbuf | acc;
        OP_XOR: fin_acc = rdbuf ^ acc;
        OP_INC: fin_acc = acc + 64'd1;
        OP_DEC: fin_acc = acc - 64'd1;
        OP_NEG: fin_acc = 64'd0 - acc;
        OP_NOT: fin_acc = ~acc;
        OP_LAND: fin_acc = 64'((rdbuf != 64'd0) && (acc != 64'd0));
        OP_LOR: fin_acc = 64'((rdbuf != 64'd0) || (acc != 64'd0));
        OP_LNOT: fin_acc = 64'(acc == 64'd0);
        OP_SHL: fin_acc = rdbuf << acc[5:0];
        OP_SHR: fin_acc = $unsigned($signed(rdbuf) >>> acc[5:0]);
        OP_EQ: fin_acc = 64'(rdbuf == acc);
        OP_NE: fin_acc = 64'(rdbuf != acc);
        OP_GT: fin_acc = 64'($signed(acc) < $signed(rdbuf));
        OP_LT: fin_acc = 64'($signed(rdbuf) < $signed(acc));
        OP_GE: fin_acc = 64'(!($signed(rdbuf) < $signed(acc)));
        OP_LE: fin_acc = 64'(!($signed(acc) < $signed(rdbuf)));
        default: begin
          if (op_q inside {[OP_IMM8:OP_IMM64]}) begin
            fin_pc = pc + OP_STEP + 32'(nbytes);
            fin_acc = sext_size(imm_q, sz);
          end else if (op_q inside {[OP_LOAD8:OP_LOAD64]}) begin
            fin_acc = sext_size(rdbuf, sz);
          end else if (op_q inside {[OP_STORE8:OP_STORE64]}) begin
            fin_sp = sp + 17'd8;
          end else if (op_q inside {[OP_PUSH8:OP_PUSH64]}) begin
            fin_sp = sp - 17'(nbytes);
          end else if (op_q inside {[OP_POP8:OP_POP64]}) begin
            fin_acc = sext_size(rdbuf, sz);
            fin_sp = sp + 17'(nbytes);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      acc <= '0;
      sp <= STACK_TOP_RESET;
      fp <= STACK_TOP_RESET;
      pc <= '0;
      stopped <= 1'b0;
      data_base <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= ((state == ST_FINISH) && out_free) || (out_valid && out_stall);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DATA_BASE: data_base <= cfg_data[15:0];
          CFG_STACK_TOP: begin
            sp <= cfg_data[PTR_W-1:0];
            fp <= cfg_data[PTR_W-1:0];
          end
          default: ;
        endcase
      end else if ((state == ST_FINISH) && out_free) begin
        acc <= fin_acc;
        sp <= fin_sp;
        fp <= fin_fp;
        pc <= fin_pc;
        stopped <= fin_stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_q <= operation;
          imm_q <= immediate;
        end
      end
      ST_START: begin
        cnt <= '0;
        rdbuf <= '0;
        fault_q <= !stopped && start_fault;
        xfer_base <= start_base[AW-1:0];
        xfer_len <= start_len;
        wdata <= start_wdata;
      end
      ST_READ: begin
        rdbuf <= rd_merged;
        if (read_done && needs_write) begin
          cnt <= '0;
          xfer_base <= acc[AW-1:0];
          xfer_len <= nbytes;
          wdata <= rd_merged;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
      ST_WRITE: cnt <= cnt + 4'd1;
      ST_FINISH: begin
        if (out_free) begin
          next_pc <= fin_pc;
          printed <= fin_print;
          print_value <= fin_print ? $signed(fin_acc[31:0]) : 32'sd0;
          halted <= fin_halt;
          fault <= fin_fault;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- verif/sam_checker.sv -----
// Checker for the stack accumulator core: tracks machine state and compares each result item.
`timescale 1ns / 1ps
module sam_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [5:0]         operation,
  input  logic signed [63:0] immediate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        next_pc,
  input  logic               printed,
  input  logic signed [31:0] print_value,
  input  logic               halted,
  input  logic               fault,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 outstanding
);
  import sam_pkg::*;

  typedef struct packed {
    logic [31:0] npc;
    logic        prt;
    logic [31:0] pval;
    logic        hlt;
    logic        flt;
  } step_result_t;

  step_result_t step_results_q[$];
  logic [7:0]   mem_img [0:65535];
  logic [63:0]  acc;
  logic [16:0]  sp;
  logic [16:0]  fp;
  logic [31:0]  pc;
  logic         stopped;
  logic [15:0]  dbase;

  function automatic logic [63:0] rd_bytes(logic [63:0] a, int n);
    logic [63:0] v = '0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | mem_img[16'(a + i)];
    return v;
  endfunction

  function automatic void wr_bytes(logic [63:0] a, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) mem_img[16'(a + i)] = v[8*i +: 8];
  endfunction

  function automatic logic fits(logic [63:0] a, int n);
    return a <= 64'd65536 - n;
  endfunction

  function automatic logic [63:0] sx(logic [63:0] v, int n);
    case (n)
      1: return {{56{v[7]}}, v[7:0]};
      2: return {{48{v[15]}}, v[15:0]};
      4: return {{32{v[31]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

  function automatic void run_instruction(logic [5:0] op, logic [63:0] imm);
    logic [63:0] a, lhs, ua, ub, q, t;
    logic [16:0] s, f;
    logic [31:0] npc;
    int n;
    logic bad, stop, prt, bin;
    step_result_t r;
    a = acc;
    lhs = '0;
    s = sp;
    f = fp;
    npc = pc + 32'd1;
    n = 1 << ((op - 6'd2) & 6'd3);
    bad = 1'b0;
    stop = 1'b0;
    prt = 1'b0;
    if (stopped) begin
      r = '{pc, 1'b0, 32'd0, 1'b1, 1'b0};
      step_results_q.push_back(r);
      return;
    end
    bin = (op >= OP_ADD && op <= OP_XOR) || op == OP_LAND || op == OP_LOR ||
          (op >= OP_SHL && op <= OP_LE);
    if (bin) begin
      if (!fits({47'd0, s}, 8)) bad = 1'b1;
      else begin
        lhs = rd_bytes({47'd0, s}, 8);
        s = s + 17'd8;
      end
    end
    if (!bad) begin
      if (op >= OP_IMM8 && op <= OP_IMM64) begin
        npc = npc + n;
        a = sx(imm, n);
      end else if (op >= OP_LOAD8 && op <= OP_LOAD64) begin
        if (!fits(a, n)) bad = 1'b1;
        else a = sx(rd_bytes(a, n), n);
      end else if (op >= OP_STORE8 && op <= OP_STORE64) begin
        if (!fits({47'd0, s}, 8) || !fits(a, n)) bad = 1'b1;
        else begin
          wr_bytes(a, n, rd_bytes({47'd0, s}, 8));
          s = s + 17'd8;
        end
      end else if (op >= OP_PUSH8 && op <= OP_PUSH64) begin
        if (s < n || s > 17'h10000) bad = 1'b1;
        else begin
          s = s - n;
          wr_bytes({47'd0, s}, n, a);
        end
      end else if (op >= OP_POP8 && op <= OP_POP64) begin
        if (!fits({47'd0, s}, n)) bad = 1'b1;
        else begin
          a = sx(rd_bytes({47'd0, s}, n), n);
          s = s + n;
        end
      end else begin
        case (op)
          OP_EXIT: stop = 1'b1;
          OP_PRINT: prt = 1'b1;
          OP_JUMP: npc = imm[31:0];
          OP_BNZ: npc = (a != 0) ? imm[31:0] : npc + 32'd4;
          OP_BZ: npc = (a == 0) ? imm[31:0] : npc + 32'd4;
          OP_CALL: begin
            if (s < 17'd8 || s > 17'h10000) bad = 1'b1;
            else begin
              wr_bytes({47'd0, s} - 64'd4, 4, {32'd0, npc + 32'd4});
              wr_bytes({47'd0, s} - 64'd8, 4, {47'd0, f});
              s = s - 17'd8;
              f = s;
              npc = imm[31:0];
            end
          end
          OP_RET: begin
            if (!fits({47'd0, f}, 8)) bad = 1'b1;
            else begin
              t = rd_bytes({47'd0, f}, 4);
              q = rd_bytes({47'd0, f} + 64'd4, 4);
              npc = q[31:0];
              s = f + 17'd8;
              f = t[16:0];
            end
          end
          OP_ADJUST: begin
            t = sx(imm, 2);
            s = s + t[16:0];
            npc = npc + 32'd2;
          end
          OP_FRAME: begin
            a = {47'd0, f} + sx(imm, 2);
            npc = npc + 32'd2;
          end
          OP_GLOBAL: begin
            a = {48'd0, dbase} + {32'd0, imm[31:0]};
            npc = npc + 32'd4;
          end
          OP_ADD: a = lhs + a;
          OP_SUB: a = lhs - a;
          OP_MUL: a = lhs * a;
          OP_DIV, OP_MOD: begin
            if (a == 0) bad = 1'b1;
            else begin
              ua = lhs[63] ? -lhs : lhs;
              ub = a[63] ? -a : a;
              if (op == OP_DIV) begin
                q = ua / ub;
                a = (lhs[63] != a[63]) ? -q : q;
              end else begin
                q = ua % ub;
                a = lhs[63] ? -q : q;
              end
            end
          end
          OP_AND: a = lhs & a;
          OP_OR: a = lhs | a;
          OP_XOR: a = lhs ^ a;
          OP_INC: a = a + 64'd1;
          OP_DEC: a = a - 64'd1;
          OP_NEG: a = -a;
          OP_NOT: a = ~a;
          OP_LAND: a = {63'd0, (lhs != 0) && (a != 0)};
          OP_LOR: a = {63'd0, (lhs != 0) || (a != 0)};
          OP_LNOT: a = {63'd0, a == 0};
          OP_SHL: a = lhs << a[5:0];
          OP_SHR: a = $unsigned($signed(lhs) >>> a[5:0]);
          OP_EQ: a = {63'd0, lhs == a};
          OP_NE: a = {63'd0, lhs != a};
          OP_GT: a = {63'd0, $signed(lhs) > $signed(a)};
          OP_LT: a = {63'd0, $signed(lhs) < $signed(a)};
          OP_GE: a = {63'd0, $signed(lhs) >= $signed(a)};
          OP_LE: a = {63'd0, $signed(lhs) <= $signed(a)};
          default: ;
        endcase
      end
    end
    if (bad) begin
      stopped = 1'b1;
      r = '{pc, 1'b0, 32'd0, 1'b1, 1'b1};
    end else begin
      acc = a;
      sp = s;
      fp = f;
      pc = npc;
      if (stop) stopped = 1'b1;
      r = '{npc, prt, prt ? a[31:0] : 32'd0, stop, 1'b0};
    end
    step_results_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    step_result_t r;
    if (rst) begin
      acc = '0;
      sp = STACK_TOP_RESET;
      fp = STACK_TOP_RESET;
      pc = '0;
      stopped = 1'b0;
      dbase = '0;
      step_results_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DATA_BASE) dbase = cfg_data[15:0];
        else if (cfg_index == CFG_STACK_TOP) begin
          sp = cfg_data[16:0];
          fp = cfg_data[16:0];
        end
      end
      if (in_valid && !in_stall) run_instruction(operation, immediate);
      if (out_valid && !out_stall) begin
        if (step_results_q.size() == 0) begin
          $error("result item with no instruction pending");
          errors++;
        end else begin
          r = step_results_q.pop_front();
          if (next_pc !== r.npc) begin
            $error("next_pc: expected %0h, actual %0h", r.npc, next_pc);
            errors++;
          end
          if (printed !== r.prt) begin
            $error("printed: expected %0b, actual %0b", r.prt, printed);
            errors++;
          end
          if (print_value !== r.pval) begin
            $error("print_value: expected %0h, actual %0h", r.pval, print_value);
            errors++;
          end
          if (halted !== r.hlt) begin
            $error("halted: expected %0b, actual %0b", r.hlt, halted);
            errors++;
          end
          if (fault !== r.flt) begin
            $error("fault: expected %0b, actual %0b", r.flt, fault);
            errors++;
          end
        end
      end
    end
    outstanding = step_results_q.size();
  end

endmodule

// ----- verif/tb_stack_accumulator_vm_core_top.sv -----
// Testbench top for the stack accumulator core: instruction stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb_stack_accumulator_vm_core_top;
  import sam_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [5:0]         operation;
  logic signed [63:0] immediate;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        next_pc;
  logic               printed;
  logic signed [31:0] print_value;
  logic               halted;
  logic               fault;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors;
  int                 outstanding;

  bit  no_idle;
  int  sent;
  int  quiet_cycles;
  int  g_sp, g_fp, g_top, g_floor, g_win;
  int  frames[$];
  bit  wr [0:65535];

  stack_accumulator_vm_core_top u_dut (.*);

  sam_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) out_stall <= !no_idle && ($urandom_range(0, 99) < 37);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("Watchdog expired with %0d results outstanding.", outstanding);
        $display("FAIL stack_accumulator_vm_core_top");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(logic [5:0] op, logic [63:0] imm);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    immediate <= imm;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // Immediate of 1, 2, 4 or 8 bytes; bits above the used size are random.
  task automatic load_imm(int sz, logic [63:0] val);
    logic [63:0] mask;
    mask = (sz == 3) ? '1 : ((64'd1 << (8 << sz)) - 1);
    send(OP_IMM8 + sz, (rnd64() & ~mask) | (val & mask));
  endtask

  task automatic do_push(int sz);
    int n;
    n = 1 << sz;
    for (int i = 1; i <= n; i++) wr[g_sp - i] = 1'b1;
    g_sp -= n;
    send(OP_PUSH8 + sz, rnd64());
  endtask

  task automatic do_call();
    frames.push_back(g_fp);
    for (int i = 1; i <= 8; i++) wr[g_sp - i] = 1'b1;
    g_sp -= 8;
    g_fp = g_sp;
    send(OP_CALL, rnd64());
  endtask

  task automatic do_ret();
    g_sp = g_fp + 8;
    g_fp = frames.pop_back();
    send(OP_RET, rnd64());
  endtask

  function automatic bit all_written(int a, int n);
    if (a < 0 || a + n > 65536) return 1'b0;
    for (int i = 0; i < n; i++) if (!wr[a + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int ceiling();
    return (frames.size() > 0) ? g_fp : g_top;
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_phase(int dbase, int top);
    drain();
    write_reg(CFG_DATA_BASE, dbase);
    write_reg(CFG_STACK_TOP, top);
    g_top = top;
    g_sp = top;
    g_fp = top;
    g_floor = top - 3000;
    frames.delete();
    if (dbase + 300 <= top - 3100) g_win = dbase;
    else if (top + 300 <= 65536) g_win = 65536 - 300;
    else g_win = 0;
  endtask

  task automatic rand_step();
    int k, sz, n, b, addr, adj;
    logic [5:0] op;
    logic [63:0] v, r;
    k = $urandom_range(0, 19);
    sz = $urandom_range(0, 3);
    n = 1 << sz;
    r = rnd64();
    case (k)
      0, 1: load_imm(sz, rnd64());
      2, 3: if (g_sp - 8 >= g_floor) do_push(sz);
      4: begin
        if (g_sp + n <= ceiling() && all_written(g_sp, n)) begin
          g_sp += n;
          send(OP_POP8 + sz, r);
        end
      end
      5, 6, 7: begin
        if (g_sp - 8 >= g_floor) begin
          b = $urandom_range(0, 17);
          if (b < 8) op = OP_ADD + b;
          else if (b == 8) op = OP_LAND;
          else if (b == 9) op = OP_LOR;
          else op = OP_SHL + (b - 10);
          load_imm($urandom_range(0, 3), rnd64());
          do_push(3);
          v = rnd64();
          if (op == OP_DIV || op == OP_MOD) begin
            if ($urandom_range(0, 1)) v = v >> $urandom_range(0, 63);
            if (v == 0) v = 64'd1;
            load_imm(3, v);
          end else begin
            load_imm($urandom_range(0, 3), v);
          end
          g_sp += 8;
          send(op, r);
        end
      end
      8, 9: begin
        if (g_sp - 8 >= g_floor) begin
          load_imm($urandom_range(0, 3), rnd64());
          do_push(3);
          addr = g_win + $urandom_range(0, 255);
          load_imm(2, addr);
          for (int i = 0; i < n; i++) wr[addr + i] = 1'b1;
          g_sp += 8;
          send(OP_STORE8 + sz, r);
        end
      end
      10, 11: begin
        addr = $urandom_range(0, 1) ? g_win + $urandom_range(0, 255)
                                    : g_sp + $urandom_range(0, 31);
        if (all_written(addr, n)) begin
          load_imm(2, addr);
          send(OP_LOAD8 + sz, r);
        end
      end
      12: send(OP_JUMP + $urandom_range(0, 2), r);
      13: if (g_sp - 8 >= g_floor && frames.size() < 40) do_call();
      14: if (frames.size() > 0) do_ret();
      15: begin
        adj = $urandom_range(0, 96) - 48;
        if (g_sp + adj >= g_floor && g_sp + adj <= ceiling()) begin
          g_sp += adj;
          send(OP_ADJUST, {r[63:16], 16'(adj)});
        end
      end
      16: send($urandom_range(0, 1) ? OP_FRAME : OP_GLOBAL, r);
      17: send(OP_INC + $urandom_range(0, 3), r);
      18: send($urandom_range(0, 1) ? OP_LNOT : OP_PRINT, r);
      default: send(6'($urandom_range(53, 63)), r);
    endcase
  endtask

  // Instructions that never touch memory, for a phase with no usable stack.
  task automatic bare_step();
    logic [63:0] r;
    r = rnd64();
    case ($urandom_range(0, 5))
      0: load_imm($urandom_range(0, 3), r);
      1: send(OP_PRINT, r);
      2: send(OP_JUMP + $urandom_range(0, 2), r);
      3: send($urandom_range(0, 1) ? OP_FRAME : OP_GLOBAL, r);
      4: send(OP_INC + $urandom_range(0, 3), r);
      default: send(6'($urandom_range(53, 63)), r);
    endcase
  endtask

  task automatic run_random(int goal, int calm_from, int calm_to);
    while (sent < goal) begin
      no_idle = (sent >= calm_from && sent < calm_to);
      rand_step();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= '0;
    immediate <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    no_idle = 1'b0;
    sent = 0;
    g_top = 65536;
    g_sp = 65536;
    g_fp = 65536;
    g_floor = 65536 - 3000;
    g_win = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Most negative divided by minus one, remainder, wrap on increment, shift masking.
    load_imm(3, 64'h8000_0000_0000_0000);
    do_push(3);
    load_imm(0, 64'hFF);
    g_sp += 8;
    send(OP_DIV, '0);
    send(OP_PRINT, '0);
    do_push(3);
    load_imm(3, '1);
    g_sp += 8;
    send(OP_MOD, '0);
    load_imm(3, 64'h7FFF_FFFF_FFFF_FFFF);
    send(OP_INC, '0);
    send(OP_PRINT, '1);
    do_push(3);
    load_imm(1, 64'h41);
    g_sp += 8;
    send(OP_SHL, '0);
    send(OP_JUMP, '1);
    do_call();
    g_sp -= 16;
    send(OP_ADJUST, 64'hFFFF_FFFF_FFFF_FFF0);
    do_ret();
    send(6'd63, '1);
    send(OP_GLOBAL, '1);
    send(OP_FRAME, 64'h8000);
    do_push(0);
    g_sp += 1;
    send(OP_POP8, '0);

    run_random(650, 300, 550);
    set_phase(65535, 8192);
    run_random(1050, 0, 0);
    set_phase(0, 0);
    repeat (20) bare_step();
    set_phase(1234, 40000);
    run_random(1470, 1300, 1400);
    set_phase(0, 65536);
    run_random(1650, 0, 0);

    case ($urandom_range(0, 3))
      0: send(OP_EXIT, rnd64());
      1: begin
        do_push(3);
        load_imm(0, 64'h0);
        send($urandom_range(0, 1) ? OP_DIV : OP_MOD, rnd64());
      end
      2: begin
        if (frames.size() == 0) send(OP_RET, rnd64());
        else begin
          load_imm(2, 64'd65535);
          send(OP_LOAD64, rnd64());
        end
      end
      default: begin
        load_imm(2, 64'd65535);
        send(OP_LOAD8 + $urandom_range(1, 3), rnd64());
      end
    endcase
    repeat (6) bare_step();

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d instructions: directed corners, five register settings,", sent);
    $display("random programs with calls and stores, then a halt and steps after it.");
    if (errors == 0) begin
      $display("PASS stack_accumulator_vm_core_top");
    end else begin
      $display("FAIL stack_accumulator_vm_core_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sam_pkg.sv
rtl/sam_ram.sv
rtl/sam_muldiv.sv
rtl/stack_accumulator_vm_core_top.sv
verif/sam_checker.sv
verif/tb_stack_accumulator_vm_core_top.sv
